// ===== rtl/core/bba_pkg.sv =====
// Shared types, codes and constants of the block bitmap allocator.
package bba_pkg;

  // Field and register widths
  localparam int REG_W      = 13;
  localparam int IDX_W      = 12;
  localparam int OP_W       = 2;
  localparam int STAT_W     = 3;
  localparam int WORD_W     = 32;
  localparam int WORD_SH    = 5;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam int IN_W       = 16;
  localparam int OUT_W      = 32;

  localparam int DEF_MAX_BLOCKS = 4096;

  // Register reset values
  localparam logic [REG_W-1:0] TOTAL_RESET    = 13'd4096;
  localparam logic [REG_W-1:0] RESERVED_RESET = 13'd1;

  // Register indexes (word index, paddr[2])
  localparam logic REG_TOTAL    = 1'b0;
  localparam logic REG_RESERVED = 1'b1;

  // Request opcodes
  localparam logic [OP_W-1:0] OP_INIT    = 2'd0;
  localparam logic [OP_W-1:0] OP_ALLOC   = 2'd1;
  localparam logic [OP_W-1:0] OP_RELEASE = 2'd2;

  typedef enum logic [STAT_W-1:0] {
    ST_OK           = 3'd0,
    ST_ALREADY_FREE = 3'd1,
    ST_FULL         = 3'd2,
    ST_BLOCK_ZERO   = 3'd3,
    ST_RANGE        = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_INIT_SWEEP,
    S_ALLOC_SCAN,
    S_REL_EVAL,
    S_REL_CHECK,
    S_DONE
  } state_t;

  typedef enum logic [1:0] {
    WR_ZERO,
    WR_PATTERN,
    WR_CLR_BIT,
    WR_SET_BIT
  } wr_src_t;

  typedef enum logic [1:0] {
    FREE_HOLD,
    FREE_LOAD,
    FREE_DEC,
    FREE_INC
  } free_op_t;

  // Controller to datapath
  typedef struct packed {
    logic     take;
    logic     cnt_clr;
    logic     cnt_inc;
    logic     rd_en;
    logic     rd_sel_idx;
    logic     wr_en;
    wr_src_t  wr_src;
    free_op_t free_op;
    logic     st_we;
    status_t  st_val;
    logic     grant_we;
    logic     load_out;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic sweep_last;
    logic scan_more;
    logic scan_hit;
    logic rd_vld;
    logic rel_zero;
    logic rel_range;
    logic rel_free;
    logic out_free;
  } stat_t;

endpackage

// ===== rtl/core/bba_cfg.sv =====
// APB register file: total and reserved block counts.
module bba_cfg import bba_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready,
  output logic [REG_W-1:0]      total_blocks,
  output logic [REG_W-1:0]      reserved_blocks
);

  logic wr;

  assign pready = 1'b1;
  assign wr     = psel & penable & pwrite;

  // Register writes in the access phase
  always_ff @(posedge clk) begin
    if (rst) begin
      total_blocks    <= TOTAL_RESET;
      reserved_blocks <= RESERVED_RESET;
    end else if (wr) begin
      if (paddr[2] == REG_TOTAL) begin
        total_blocks <= pwdata[REG_W-1:0];
      end else begin
        reserved_blocks <= pwdata[REG_W-1:0];
      end
    end
  end

  // Read mux
  always_comb begin
    if (paddr[2] == REG_RESERVED) begin
      prdata = CFG_DATA_W'(reserved_blocks);
    end else begin
      prdata = CFG_DATA_W'(total_blocks);
    end
  end

endmodule

// ===== rtl/core/bba_datapath.sv =====
// Datapath: bitmap memory, word counter, first-free search, free count, result register.
module bba_datapath import bba_pkg::*; #(
  parameter int MAX_BLOCKS = DEF_MAX_BLOCKS
) (
  input  logic             clk,
  input  logic             rst,
  input  cmd_t             cmd,
  output stat_t            stat,
  input  logic [IDX_W-1:0] in_idx,
  input  logic [REG_W-1:0] total_blocks,
  input  logic [REG_W-1:0] reserved_blocks,
  input  logic             out_ready,
  output logic             out_valid,
  output logic [OUT_W-1:0] out_data
);

  localparam int MAP_WORDS = (MAX_BLOCKS + WORD_W - 1) / WORD_W;
  localparam int AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int CW        = AW + 1;
  localparam int NEED_W    = REG_W + 1 - WORD_SH;
  localparam int XW        = (CW > NEED_W) ? CW : NEED_W;
  localparam int IW        = (AW + WORD_SH > REG_W) ? AW + WORD_SH : REG_W;
  localparam int FW        = $clog2(MAX_BLOCKS + 1);

  logic [WORD_W-1:0] mem [MAP_WORDS];

  logic [IDX_W-1:0]   idx_q;
  logic [CW-1:0]      cnt;
  logic [WORD_W-1:0]  rd_data;
  logic [AW-1:0]      rd_word;
  logic               rd_vld;
  logic [FW-1:0]      free_total;
  status_t            res_status;
  logic [IDX_W-1:0]   res_grant;
  status_t            out_status;
  logic [IDX_W-1:0]   out_grant;
  logic [REG_W-1:0]   out_free;

  logic [REG_W-1:0]   tot;
  logic [REG_W-1:0]   res_raw;
  logic [REG_W-1:0]   res;
  logic [REG_W:0]     tot_round;
  logic [NEED_W-1:0]  need;
  logic [IW-1:0]      idx_ext;
  logic [AW-1:0]      idx_word;
  logic [AW-1:0]      rd_addr;
  logic [AW-1:0]      wr_addr;
  logic [WORD_W-1:0]  wr_data;
  logic [WORD_W-1:0]  pattern;
  logic [WORD_W-1:0]  avail;
  logic [WORD_SH-1:0] pos;
  logic [IW-1:0]      grant_ext;

  // Effective total and reserved counts
  always_comb begin
    tot       = (32'(total_blocks) > MAX_BLOCKS) ? REG_W'(MAX_BLOCKS) : total_blocks;
    res_raw   = (reserved_blocks == '0) ? REG_W'(1) : reserved_blocks;
    res       = (res_raw > tot) ? tot : res_raw;
    tot_round = {1'b0, tot} + (REG_W + 1)'(WORD_W - 1);
    need      = tot_round[REG_W:WORD_SH];
  end

  assign idx_ext  = IW'(idx_q);
  assign idx_word = idx_ext[AW+WORD_SH-1:WORD_SH];
  assign rd_addr  = cmd.rd_sel_idx ? idx_word : cnt[AW-1:0];

  // Init pattern for the word under the counter
  always_comb begin
    logic [IW-1:0] ib;
    for (int b = 0; b < WORD_W; b++) begin
      ib         = IW'({cnt[AW-1:0], WORD_SH'(b)});
      pattern[b] = (ib >= IW'(res)) && (ib < IW'(tot));
    end
  end

  // Free bits of the fetched word that lie below the total
  always_comb begin
    logic [IW-1:0] ib;
    for (int b = 0; b < WORD_W; b++) begin
      ib       = IW'({rd_word, WORD_SH'(b)});
      avail[b] = rd_data[b] & (ib < IW'(tot));
    end
  end

  // Lowest set bit
  always_comb begin
    pos = '0;
    for (int b = WORD_W - 1; b >= 0; b--) begin
      if (avail[b]) begin
        pos = WORD_SH'(b);
      end
    end
  end

  assign grant_ext = IW'({rd_word, pos});

  // Write port data and address
  always_comb begin
    case (cmd.wr_src)
      WR_ZERO:    wr_data = '0;
      WR_PATTERN: wr_data = pattern;
      WR_CLR_BIT: wr_data = rd_data & ~(WORD_W'(1) << pos);
      WR_SET_BIT: wr_data = rd_data | (WORD_W'(1) << idx_q[WORD_SH-1:0]);
      default:    wr_data = '0;
    endcase
    if (cmd.wr_src == WR_ZERO || cmd.wr_src == WR_PATTERN) begin
      wr_addr = cnt[AW-1:0];
    end else begin
      wr_addr = rd_word;
    end
  end

  // Bitmap memory, one write and one registered read
  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.rd_en) begin
      rd_data <= mem[rd_addr];
      rd_word <= rd_addr;
    end
  end

  // Request payload and pending result
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      idx_q <= in_idx;
    end
    if (cmd.st_we) begin
      res_status <= cmd.st_val;
      res_grant  <= cmd.grant_we ? grant_ext[IDX_W-1:0] : '0;
    end
    if (cmd.load_out) begin
      out_status <= res_status;
      out_grant  <= res_grant;
      out_free   <= REG_W'(free_total);
    end
  end

  // Control registers: counter, read valid, free count, output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt        <= '0;
      rd_vld     <= 1'b0;
      free_total <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (cmd.cnt_clr) begin
        cnt <= '0;
      end else if (cmd.cnt_inc) begin
        cnt <= cnt + CW'(1);
      end
      rd_vld <= cmd.rd_en;
      case (cmd.free_op)
        FREE_LOAD: free_total <= FW'(tot - res);
        FREE_DEC: begin
          if (free_total != '0) begin
            free_total <= free_total - FW'(1);
          end
        end
        FREE_INC: begin
          if (32'(free_total) < MAX_BLOCKS) begin
            free_total <= free_total + FW'(1);
          end
        end
        default: ;
      endcase
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Status toward the controller
  always_comb begin
    stat.sweep_last = (cnt == CW'(MAP_WORDS - 1));
    stat.scan_more  = (XW'(cnt) < XW'(need));
    stat.scan_hit   = rd_vld & (|avail);
    stat.rd_vld     = rd_vld;
    stat.rel_zero   = (idx_q == '0);
    stat.rel_range  = ({1'b0, idx_q} >= tot);
    stat.rel_free   = rd_data[idx_q[WORD_SH-1:0]];
    stat.out_free   = ~out_valid | out_ready;
  end

  assign out_data = {(OUT_W - REG_W - IDX_W - STAT_W)'(0), out_free, out_grant, out_status};

endmodule

// ===== rtl/core/bba_ctrl.sv =====
// Controller: sequences clear, init sweep, first-free scan and release per request.
module bba_ctrl import bba_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  logic [OP_W-1:0] in_op,
  output logic            in_ready,
  input  stat_t           stat,
  output cmd_t            cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: begin
        if (stat.sweep_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          case (in_op)
            OP_INIT:    state_next = S_INIT_SWEEP;
            OP_ALLOC:   state_next = S_ALLOC_SCAN;
            OP_RELEASE: state_next = S_REL_EVAL;
            default:    state_next = S_DONE;
          endcase
        end
      end
      S_INIT_SWEEP: begin
        if (stat.sweep_last) state_next = S_DONE;
      end
      S_ALLOC_SCAN: begin
        if (stat.scan_hit || (!stat.scan_more && !stat.rd_vld)) state_next = S_DONE;
      end
      S_REL_EVAL: begin
        if (stat.rel_zero || stat.rel_range) begin
          state_next = S_DONE;
        end else begin
          state_next = S_REL_CHECK;
        end
      end
      S_REL_CHECK: state_next = S_DONE;
      S_DONE: begin
        if (stat.out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Commands
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state)
      S_CLEAR: begin
        cmd.wr_en   = 1'b1;
        cmd.wr_src  = WR_ZERO;
        cmd.cnt_inc = 1'b1;
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.take    = 1'b1;
          cmd.cnt_clr = 1'b1;
          case (in_op)
            OP_INIT: begin
              cmd.st_we   = 1'b1;
              cmd.st_val  = ST_OK;
              cmd.free_op = FREE_LOAD;
            end
            OP_ALLOC, OP_RELEASE: ;
            default: begin
              cmd.st_we  = 1'b1;
              cmd.st_val = ST_RANGE;
            end
          endcase
        end
      end
      S_INIT_SWEEP: begin
        cmd.wr_en   = 1'b1;
        cmd.wr_src  = WR_PATTERN;
        cmd.cnt_inc = 1'b1;
      end
      S_ALLOC_SCAN: begin
        // reads stream one word a cycle; the hit is taken in the cycle after its read
        cmd.rd_en   = stat.scan_more;
        cmd.cnt_inc = stat.scan_more;
        if (stat.scan_hit) begin
          cmd.wr_en    = 1'b1;
          cmd.wr_src   = WR_CLR_BIT;
          cmd.free_op  = FREE_DEC;
          cmd.st_we    = 1'b1;
          cmd.st_val   = ST_OK;
          cmd.grant_we = 1'b1;
        end else if (!stat.scan_more && !stat.rd_vld) begin
          cmd.st_we  = 1'b1;
          cmd.st_val = ST_FULL;
        end
      end
      S_REL_EVAL: begin
        if (stat.rel_zero) begin
          cmd.st_we  = 1'b1;
          cmd.st_val = ST_BLOCK_ZERO;
        end else if (stat.rel_range) begin
          cmd.st_we  = 1'b1;
          cmd.st_val = ST_RANGE;
        end else begin
          cmd.rd_en      = 1'b1;
          cmd.rd_sel_idx = 1'b1;
        end
      end
      S_REL_CHECK: begin
        cmd.st_we = 1'b1;
        if (stat.rel_free) begin
          cmd.st_val = ST_ALREADY_FREE;
        end else begin
          cmd.st_val  = ST_OK;
          cmd.wr_en   = 1'b1;
          cmd.wr_src  = WR_SET_BIT;
          cmd.free_op = FREE_INC;
        end
      end
      S_DONE: begin
        cmd.load_out = stat.out_free;
      end
      default: ;
    endcase
  end

endmodule

// ===== rtl/core/block_bitmap_allocator.sv =====
// Top level of the first-fit free-block bitmap allocator.
// One bit per block, 1 = free, held in a memory of ceil(MAX_BLOCKS/32) 32-bit words.
// Requests are handled one at a time. After reset a clearing pass writes every map word
// to zero, one word a cycle, before the first request is taken; configuration writes
// are accepted meanwhile. Init writes one map word per cycle. Allocate reads one word
// a cycle through the single read port of the map, from block 0 upward, and ends at
// the first free block below the total, or reports full when none is free. A finished
// result sits in an output register, so the next request is taken while it waits for
// m_tready. Write the registers only while no request is in flight.
module block_bitmap_allocator import bba_pkg::*; #(
  parameter int MAX_BLOCKS = DEF_MAX_BLOCKS
) (
  input  logic                  clk,
  input  logic                  rst,
  // request: [1:0] op, [13:2] block_index, [15:14] zero
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_W-1:0]       s_tdata,
  // result: [2:0] status, [14:3] granted_block, [27:15] free_blocks, [31:28] zero
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_W-1:0]      m_tdata,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  logic [REG_W-1:0] total_blocks;
  logic [REG_W-1:0] reserved_blocks;
  cmd_t             cmd;
  stat_t            stat;

  bba_cfg u_cfg (
    .clk             (clk),
    .rst             (rst),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .total_blocks    (total_blocks),
    .reserved_blocks (reserved_blocks)
  );

  bba_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_op    (s_tdata[OP_W-1:0]),
    .in_ready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  bba_datapath #(
    .MAX_BLOCKS (MAX_BLOCKS)
  ) u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .stat            (stat),
    .in_idx          (s_tdata[OP_W+IDX_W-1:OP_W]),
    .total_blocks    (total_blocks),
    .reserved_blocks (reserved_blocks),
    .out_ready       (m_tready),
    .out_valid       (m_tvalid),
    .out_data        (m_tdata)
  );

endmodule

// ===== sim/tb_top.sv =====
// Self-checking testbench for the first-fit block bitmap allocator.
`timescale 1ns / 100ps

module tb_top;
  import bba_pkg::*;

  localparam int MAX_BLK = DEF_MAX_BLOCKS;
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  typedef struct {
    logic [OP_W-1:0]  op;
    logic [IDX_W-1:0] idx;
  } alloc_req_t;

  typedef struct {
    status_t          status;
    logic [IDX_W-1:0] granted;
    logic [REG_W-1:0] free_cnt;
  } alloc_rsp_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_W-1:0]       s_tdata = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_W-1:0]      m_tdata;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr = '0;
  logic [CFG_DATA_W-1:0] pwdata = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  // Shadow of the allocator state and registers
  bit               shadow_map [MAX_BLK];
  logic [REG_W-1:0] shadow_free = '0;
  logic [REG_W-1:0] cfg_total = TOTAL_RESET;
  logic [REG_W-1:0] cfg_reserved = RESERVED_RESET;

  alloc_req_t request_queue[$];
  alloc_rsp_t pending_results[$];
  int         err_count = 0;
  int         queued = 0;
  bit         calm = 1'b0;
  int         send_gap = 0;
  int         recv_stall = 0;

  block_bitmap_allocator u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),   // [1:0] op, [13:2] block_index, [15:14] zero
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),   // [2:0] status, [14:3] granted_block, [27:15] free_blocks
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always #5 clk = ~clk;

  // Apply one request to the shadow map and return the expected result
  function automatic alloc_rsp_t apply_request(alloc_req_t r);
    alloc_rsp_t rsp;
    int tot;
    int res;
    int i;
    bit found;
    rsp.status = ST_OK;
    rsp.granted = '0;
    tot = (cfg_total > MAX_BLK) ? MAX_BLK : int'(cfg_total);
    case (r.op)
      OP_INIT: begin
        res = (cfg_reserved == 0) ? 1 : int'(cfg_reserved);
        if (res > tot) res = tot;
        for (i = 0; i < MAX_BLK; i++) shadow_map[i] = (i >= res) && (i < tot);
        shadow_free = REG_W'(tot - res);
      end
      OP_ALLOC: begin
        found = 1'b0;
        for (i = 0; i < tot; i++) begin
          if (shadow_map[i]) begin
            found = 1'b1;
            break;
          end
        end
        if (found) begin
          shadow_map[i] = 1'b0;
          rsp.granted = IDX_W'(i);
          if (shadow_free != 0) shadow_free = shadow_free - 1'b1;
        end else begin
          rsp.status = ST_FULL;
        end
      end
      OP_RELEASE: begin
        if (r.idx == 0) rsp.status = ST_BLOCK_ZERO;
        else if (int'(r.idx) >= tot) rsp.status = ST_RANGE;
        else if (shadow_map[r.idx]) rsp.status = ST_ALREADY_FREE;
        else begin
          shadow_map[r.idx] = 1'b1;
          if (shadow_free < MAX_BLK) shadow_free = shadow_free + 1'b1;
        end
      end
      default: rsp.status = ST_RANGE;
    endcase
    rsp.free_cnt = shadow_free;
    return rsp;
  endfunction

  task automatic report_mismatch(string what, int expv, int gotv);
    $display("[%0t] MISMATCH %s: expected %0d, got %0d", $time, what, expv, gotv);
    err_count++;
  endtask

  // Request driver: presents the queue head, with random idle bursts
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      send_gap <= 0;
    end else begin
      if (s_tvalid && s_tready) begin
        pending_results.push_back(apply_request(request_queue[0]));
        void'(request_queue.pop_front());
      end
      if (s_tvalid && !s_tready) begin
        // hold the request until taken
      end else if (send_gap != 0) begin
        send_gap <= send_gap - 1;
        s_tvalid <= 1'b0;
      end else if (!calm && $urandom_range(0, 15) == 0) begin
        send_gap <= $urandom_range(0, 17);
        s_tvalid <= 1'b0;
      end else if (request_queue.size() != 0) begin
        s_tvalid <= 1'b1;
        s_tdata <= {2'b00, request_queue[0].idx, request_queue[0].op};
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Result monitor and random backpressure
  always @(posedge clk) begin
    alloc_rsp_t exp_rsp;
    if (rst) begin
      m_tready <= 1'b0;
      recv_stall <= 0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (pending_results.size() == 0) begin
          report_mismatch("result with no request outstanding", 0, int'(m_tdata));
        end else begin
          exp_rsp = pending_results.pop_front();
          if (m_tdata[2:0] !== exp_rsp.status)
            report_mismatch("status", int'(exp_rsp.status), int'(m_tdata[2:0]));
          if (m_tdata[14:3] !== exp_rsp.granted)
            report_mismatch("granted_block", int'(exp_rsp.granted), int'(m_tdata[14:3]));
          if (m_tdata[27:15] !== exp_rsp.free_cnt)
            report_mismatch("free_blocks", int'(exp_rsp.free_cnt), int'(m_tdata[27:15]));
        end
      end
      if (recv_stall != 0) begin
        recv_stall <= recv_stall - 1;
        m_tready <= 1'b0;
      end else if (!calm && $urandom_range(0, 15) == 0) begin
        recv_stall <= $urandom_range(0, 17);
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  task automatic queue_req(logic [OP_W-1:0] op, logic [IDX_W-1:0] idx);
    alloc_req_t r;
    r.op = op;
    r.idx = idx;
    request_queue.push_back(r);
    queued++;
  endtask

  // APB write: setup then access; shadow register follows the write edge
  task automatic cfg_write(logic reg_idx, logic [REG_W-1:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {reg_idx, 2'b00};
    pwdata <= CFG_DATA_W'(value);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (reg_idx == REG_TOTAL) cfg_total = value;
    else cfg_reserved = value;
  endtask

  // Wait until every request has been taken and answered
  task automatic wait_idle();
    do @(negedge clk);
    while (request_queue.size() != 0 || s_tvalid || pending_results.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  // One random setting followed by a mostly well-formed request sequence
  task automatic random_phase(int n);
    int sel;
    int tot_pick;
    int res_pick;
    int hi;
    int k;
    int r;
    sel = $urandom_range(0, 9);
    if (sel < 6) tot_pick = $urandom_range(1, 300);
    else if (sel < 8) tot_pick = MAX_BLK;
    else tot_pick = $urandom_range(0, 8191);
    sel = $urandom_range(0, 9);
    if (sel < 7) res_pick = $urandom_range(0, 40);
    else if (sel < 9) res_pick = $urandom_range(0, (tot_pick + 2 > 8191) ? 8191 : tot_pick + 2);
    else res_pick = $urandom_range(0, 8191);
    sel = $urandom_range(0, 3);
    if (sel != 1) cfg_write(REG_TOTAL, REG_W'(tot_pick));
    if (sel != 0) cfg_write(REG_RESERVED, REG_W'(res_pick));
    @(negedge clk);
    // mostly start from a fresh map; otherwise keep the old map under the new total
    if ($urandom_range(0, 7) != 0) queue_req(OP_INIT, IDX_W'($urandom));
    hi = ((cfg_total > MAX_BLK) ? MAX_BLK : int'(cfg_total)) + 3;
    if (hi > MAX_BLK - 1) hi = MAX_BLK - 1;
    for (k = 0; k < n; k++) begin
      r = $urandom_range(0, 99);
      if (r < 45) queue_req(OP_ALLOC, IDX_W'($urandom));
      else if (r < 85) queue_req(OP_RELEASE, IDX_W'($urandom_range(0, hi)));
      else if (r < 95) queue_req(OP_RELEASE, IDX_W'($urandom));
      else if (r < 98) queue_req(OP_INIT, IDX_W'($urandom));
      else queue_req(OP_UNUSED, IDX_W'($urandom));
    end
  endtask

  // Stimulus sequence
  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    cfg_write(REG_TOTAL, 13'd4096);
    cfg_write(REG_RESERVED, 13'd1);
    @(negedge clk);

    // map still all used after reset, then a full-size init
    queue_req(OP_ALLOC, 12'd0);
    queue_req(OP_RELEASE, 12'd0);
    queue_req(OP_RELEASE, 12'd4095);
    queue_req(OP_UNUSED, 12'hFFF);
    queue_req(OP_ALLOC, 12'hFFF);
    queue_req(OP_INIT, 12'hABC);
    queue_req(OP_ALLOC, 12'd0);
    queue_req(OP_ALLOC, 12'd0);
    queue_req(OP_RELEASE, 12'd2);
    queue_req(OP_RELEASE, 12'd2);
    queue_req(OP_ALLOC, 12'd0);
    queue_req(OP_RELEASE, 12'd4095);
    wait_idle();

    // reserved zero acts as one; releases at and past the total
    cfg_write(REG_TOTAL, 13'd20);
    cfg_write(REG_RESERVED, 13'd0);
    @(negedge clk);
    queue_req(OP_INIT, 12'd0);
    queue_req(OP_RELEASE, 12'd20);
    queue_req(OP_RELEASE, 12'd19);
    queue_req(OP_RELEASE, 12'd4095);
    queue_req(OP_ALLOC, 12'd0);
    wait_idle();

    // oversized total clamps; high blocks granted until full
    cfg_write(REG_TOTAL, 13'd8191);
    cfg_write(REG_RESERVED, 13'd4090);
    @(negedge clk);
    queue_req(OP_INIT, 12'd0);
    repeat (7) queue_req(OP_ALLOC, 12'd0);
    queue_req(OP_RELEASE, 12'd4095);
    queue_req(OP_ALLOC, 12'd0);
    wait_idle();

    // zero total, reserved past total, single-block volume
    cfg_write(REG_TOTAL, 13'd0);
    @(negedge clk);
    queue_req(OP_INIT, 12'd0);
    queue_req(OP_ALLOC, 12'd0);
    queue_req(OP_RELEASE, 12'd1);
    wait_idle();
    cfg_write(REG_TOTAL, 13'd5);
    cfg_write(REG_RESERVED, 13'd8191);
    @(negedge clk);
    queue_req(OP_INIT, 12'd0);
    queue_req(OP_ALLOC, 12'd0);
    wait_idle();
    cfg_write(REG_TOTAL, 13'd1);
    cfg_write(REG_RESERVED, 13'd1);
    @(negedge clk);
    queue_req(OP_INIT, 12'd0);
    queue_req(OP_ALLOC, 12'd0);
    wait_idle();

    // random phases, each waiting out the previous one
    while (queued < 640) begin
      random_phase($urandom_range(20, 80));
      wait_idle();
    end

    // closing stretch at full rate
    calm = 1'b1;
    random_phase(60);
    wait_idle();
    repeat (140) @(posedge clk);
    if (err_count == 0) begin
      $display("block_bitmap_allocator verification clean");
    end else begin
      $display("block_bitmap_allocator verification failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #10_000_000;
    $display("block_bitmap_allocator verification failed");
    $finish;
  end

endmodule
